// ===== src/bced_pkg.sv =====
// Package for the button click event detector: transaction payload types,
// event, phase and register index codes. No dependencies.
package bced_pkg;

    // Event codes reported once per contact sample
    localparam logic [2:0] EV_RELEASED = 3'd0;
    localparam logic [2:0] EV_PRESSED  = 3'd1;
    localparam logic [2:0] EV_DOWN     = 3'd2;
    localparam logic [2:0] EV_LONG     = 3'd3;
    localparam logic [2:0] EV_REPEAT   = 3'd4;
    localparam logic [2:0] EV_CLICKED  = 3'd5;
    localparam logic [2:0] EV_DOUBLE   = 3'd6;

    // Phase codes of the click machine
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_SEEN       = 4'd1;
    localparam logic [3:0] PH_HELD       = 4'd2;
    localparam logic [3:0] PH_LONG_HELD  = 4'd3;
    localparam logic [3:0] PH_RELEASING  = 4'd4;
    localparam logic [3:0] PH_WAIT_2ND   = 4'd5;
    localparam logic [3:0] PH_SEEN_2ND   = 4'd6;
    localparam logic [3:0] PH_HELD_2ND   = 4'd7;
    localparam logic [3:0] PH_RELEASE_2ND = 4'd8;

    // Configuration register indexes
    localparam logic [7:0] REG_DEBOUNCE      = 8'd0;
    localparam logic [7:0] REG_LONG_PRESS    = 8'd1;
    localparam logic [7:0] REG_REPEAT        = 8'd2;
    localparam logic [7:0] REG_DOUBLE_WINDOW = 8'd3;

    // Register reset values
    localparam logic [15:0] RST_DEBOUNCE      = 16'd20;
    localparam logic [15:0] RST_LONG_PRESS    = 16'd1000;
    localparam logic [15:0] RST_REPEAT        = 16'd200;
    localparam logic [15:0] RST_DOUBLE_WINDOW = 16'd300;

    typedef struct packed {
        logic        pressed;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  index;
        logic [15:0] data;
    } t_cfg_item;

    // Threshold set handed from the register file to the machine
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_ms;
        logic [15:0] double_window_ms;
    } t_cfg_regs;

endpackage

// ===== src/bced_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
// Payload type is supplied by the instantiating scope (types in bced_pkg).
interface bced_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bced_cfg_regs.sv =====
// Configuration register file for the click detector thresholds.
// Depends on bced_pkg and bced_chan_if.
module bced_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bced_chan_if.sink           i_cfg,
    output bced_pkg::t_cfg_regs o_regs
);
    bced_pkg::t_cfg_regs r_regs;

    // Always take a write transaction
    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    // Update the addressed register, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.debounce_ms      <= bced_pkg::RST_DEBOUNCE;
            r_regs.long_press_ms    <= bced_pkg::RST_LONG_PRESS;
            r_regs.repeat_ms        <= bced_pkg::RST_REPEAT;
            r_regs.double_window_ms <= bced_pkg::RST_DOUBLE_WINDOW;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                bced_pkg::REG_DEBOUNCE:      r_regs.debounce_ms      <= i_cfg.payload.data;
                bced_pkg::REG_LONG_PRESS:    r_regs.long_press_ms    <= i_cfg.payload.data;
                bced_pkg::REG_REPEAT:        r_regs.repeat_ms        <= i_cfg.payload.data;
                bced_pkg::REG_DOUBLE_WINDOW: r_regs.double_window_ms <= i_cfg.payload.data;
                default: ;
            endcase
        end
    end
endmodule

// ===== src/bced_fsm.sv =====
// Click machine: phase and timestamp state, one elapsed-time compare per step.
// Depends on bced_pkg.
module bced_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  bced_pkg::t_in_item  i_item,
    input  bced_pkg::t_cfg_regs i_regs,
    output logic [2:0]          o_event
);
    logic [3:0]  r_phase;
    logic [31:0] r_stamp_ms;
    logic [3:0]  n_phase;
    logic [31:0] n_stamp_ms;
    logic [15:0] limit;
    logic [31:0] elapsed;
    logic        passed;
    logic        down;

    assign down = i_item.pressed;

    // Pick the threshold that the current phase compares against
    always_comb begin
        case (r_phase)
            bced_pkg::PH_HELD, bced_pkg::PH_HELD_2ND: limit = i_regs.long_press_ms;
            bced_pkg::PH_LONG_HELD:                   limit = i_regs.repeat_ms;
            bced_pkg::PH_WAIT_2ND:                    limit = i_regs.double_window_ms;
            default:                                  limit = i_regs.debounce_ms;
        endcase
    end

    // Wrapping elapsed time, strictly greater than the threshold
    assign elapsed = i_item.now_ms - r_stamp_ms;
    assign passed  = elapsed > {16'd0, limit};

    // Next phase, stamp and event
    always_comb begin
        n_phase    = r_phase;
        n_stamp_ms = r_stamp_ms;
        o_event    = bced_pkg::EV_RELEASED;
        case (r_phase)
            bced_pkg::PH_IDLE: begin
                if (down) begin
                    n_stamp_ms = i_item.now_ms;
                    n_phase    = bced_pkg::PH_SEEN;
                end
            end
            bced_pkg::PH_SEEN, bced_pkg::PH_SEEN_2ND: begin
                if (down) begin
                    if (passed) begin
                        o_event    = bced_pkg::EV_PRESSED;
                        n_stamp_ms = i_item.now_ms;
                        n_phase    = (r_phase == bced_pkg::PH_SEEN) ?
                                     bced_pkg::PH_HELD : bced_pkg::PH_HELD_2ND;
                    end
                end else begin
                    n_phase = (r_phase == bced_pkg::PH_SEEN) ?
                              bced_pkg::PH_IDLE : bced_pkg::PH_WAIT_2ND;
                end
            end
            bced_pkg::PH_HELD, bced_pkg::PH_HELD_2ND: begin
                if (down) begin
                    if (passed) begin
                        o_event    = bced_pkg::EV_LONG;
                        n_stamp_ms = i_item.now_ms;
                        n_phase    = bced_pkg::PH_LONG_HELD;
                    end else begin
                        o_event = bced_pkg::EV_DOWN;
                    end
                end else begin
                    n_stamp_ms = i_item.now_ms;
                    n_phase    = (r_phase == bced_pkg::PH_HELD) ?
                                 bced_pkg::PH_RELEASING : bced_pkg::PH_RELEASE_2ND;
                end
            end
            bced_pkg::PH_LONG_HELD: begin
                if (down) begin
                    if (passed) begin
                        o_event    = bced_pkg::EV_REPEAT;
                        n_stamp_ms = i_item.now_ms;
                    end else begin
                        o_event = bced_pkg::EV_DOWN;
                    end
                end else begin
                    // Release from a long hold skips the debounce
                    n_phase = bced_pkg::PH_IDLE;
                end
            end
            bced_pkg::PH_RELEASING, bced_pkg::PH_RELEASE_2ND: begin
                if (down) begin
                    // Bounce while releasing: back to held, stamp kept
                    n_phase = (r_phase == bced_pkg::PH_RELEASING) ?
                              bced_pkg::PH_HELD : bced_pkg::PH_HELD_2ND;
                end else if (passed) begin
                    o_event    = (r_phase == bced_pkg::PH_RELEASING) ?
                                 bced_pkg::EV_CLICKED : bced_pkg::EV_DOUBLE;
                    n_stamp_ms = i_item.now_ms;
                    n_phase    = (r_phase == bced_pkg::PH_RELEASING) ?
                                 bced_pkg::PH_WAIT_2ND : bced_pkg::PH_IDLE;
                end
            end
            bced_pkg::PH_WAIT_2ND: begin
                if (down) begin
                    n_stamp_ms = i_item.now_ms;
                    n_phase    = bced_pkg::PH_SEEN_2ND;
                end else if (passed) begin
                    n_phase = bced_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = bced_pkg::PH_IDLE;
            end
        endcase
    end

    // Advance the state once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bced_pkg::PH_IDLE;
            r_stamp_ms <= 32'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_stamp_ms <= n_stamp_ms;
        end
    end
endmodule

// ===== src/button_click_event_detector_unit.sv =====
// Button click event detector, top level. Depends on bced_pkg, bced_chan_if,
// bced_cfg_regs and bced_fsm.
// A sample taken into the input register has its event registered in the
// result register once that is free. Throughput: one sample per cycle
// unless the result side stalls; the input and result registers decouple
// the channels. Reset restores the default thresholds and the idle phase.
module button_click_event_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bced_chan_if.sink   i_in,
    bced_chan_if.source o_out,
    bced_chan_if.sink   i_cfg
);
    bced_pkg::t_cfg_regs regs;
    bced_pkg::t_in_item  r_in_item;
    logic                r_in_valid;
    logic [2:0]          r_event;
    logic                r_out_valid;
    logic [2:0]          step_event;
    logic                advance;
    logic                in_take;

    bced_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (regs)
    );

    // Process the held sample when the result register is free
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    bced_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_item),
        .i_regs  (regs),
        .o_event (step_event)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in.payload;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= step_event;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.payload.event_res = r_event;
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for button_click_event_detector_unit: predicts the event code of
// every accepted contact sample and checks the results in order.
// Depends on bced_pkg, bced_chan_if and the RTL under src.
module tb_top;
    import bced_pkg::*;

    // Tracks the click machine and holds the event codes still due from the block
    class click_event_book;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_ms;
        logic [15:0] window_ms;
        logic [3:0]  click_phase;
        logic [31:0] stamp_ms;
        logic [2:0]  due_events[$];
        int          failures;

        function new();
            debounce_ms   = RST_DEBOUNCE;
            long_press_ms = RST_LONG_PRESS;
            repeat_ms     = RST_REPEAT;
            window_ms     = RST_DOUBLE_WINDOW;
            click_phase   = PH_IDLE;
            stamp_ms      = '0;
            failures      = 0;
        endfunction

        // Update a threshold; indexes past the last register are dropped
        function void write_reg(t_cfg_item w);
            case (w.index)
                REG_DEBOUNCE:      debounce_ms   = w.data;
                REG_LONG_PRESS:    long_press_ms = w.data;
                REG_REPEAT:        repeat_ms     = w.data;
                REG_DOUBLE_WINDOW: window_ms     = w.data;
                default: ;
            endcase
        endfunction

        // Strict compare of the wrapped elapsed time against a threshold
        function bit lapsed_past(logic [31:0] now, logic [15:0] lim);
            return (now - stamp_ms) > {16'd0, lim};
        endfunction

        // Advance the machine by one sample and queue the event it yields
        function void take_sample(t_in_item s);
            logic [2:0] ev;
            ev = EV_RELEASED;
            case (click_phase)
                PH_IDLE: begin
                    if (s.pressed) begin
                        stamp_ms    = s.now_ms;
                        click_phase = PH_SEEN;
                    end
                end
                PH_SEEN, PH_SEEN_2ND: begin
                    if (s.pressed) begin
                        if (lapsed_past(s.now_ms, debounce_ms)) begin
                            ev          = EV_PRESSED;
                            stamp_ms    = s.now_ms;
                            click_phase = (click_phase == PH_SEEN) ? PH_HELD : PH_HELD_2ND;
                        end
                    end else begin
                        click_phase = (click_phase == PH_SEEN) ? PH_IDLE : PH_WAIT_2ND;
                    end
                end
                PH_HELD, PH_HELD_2ND: begin
                    if (s.pressed) begin
                        if (lapsed_past(s.now_ms, long_press_ms)) begin
                            ev          = EV_LONG;
                            stamp_ms    = s.now_ms;
                            click_phase = PH_LONG_HELD;
                        end else begin
                            ev = EV_DOWN;
                        end
                    end else begin
                        stamp_ms    = s.now_ms;
                        click_phase = (click_phase == PH_HELD) ? PH_RELEASING : PH_RELEASE_2ND;
                    end
                end
                PH_LONG_HELD: begin
                    if (s.pressed) begin
                        if (lapsed_past(s.now_ms, repeat_ms)) begin
                            ev       = EV_REPEAT;
                            stamp_ms = s.now_ms;
                        end else begin
                            ev = EV_DOWN;
                        end
                    end else begin
                        click_phase = PH_IDLE;
                    end
                end
                PH_RELEASING, PH_RELEASE_2ND: begin
                    // a bounce back to closed returns to the held phase, stamp kept
                    if (s.pressed) begin
                        click_phase = (click_phase == PH_RELEASING) ? PH_HELD : PH_HELD_2ND;
                    end else if (lapsed_past(s.now_ms, debounce_ms)) begin
                        ev          = (click_phase == PH_RELEASING) ? EV_CLICKED : EV_DOUBLE;
                        stamp_ms    = s.now_ms;
                        click_phase = (click_phase == PH_RELEASING) ? PH_WAIT_2ND : PH_IDLE;
                    end
                end
                PH_WAIT_2ND: begin
                    if (s.pressed) begin
                        stamp_ms    = s.now_ms;
                        click_phase = PH_SEEN_2ND;
                    end else if (lapsed_past(s.now_ms, window_ms)) begin
                        click_phase = PH_IDLE;
                    end
                end
                default: click_phase = PH_IDLE;
            endcase
            due_events.push_back(ev);
        endfunction

        // Compare one result with the oldest due event
        function void match_event(t_out_item got);
            logic [2:0] want;
            if (due_events.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected event %0d with nothing due", got.event_res);
                return;
            end
            want = due_events.pop_front();
            if (got.event_res !== want) begin
                failures++;
                if (failures <= 10)
                    $display("event_res mismatch: expected %0d, actual %0d",
                             want, got.event_res);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bced_chan_if #(.t_payload(t_in_item))  in_ch ();
    bced_chan_if #(.t_payload(t_out_item)) out_ch ();
    bced_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();

    button_click_event_detector_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    click_event_book book = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold_req;
    int unsigned hold_left;
    logic [31:0] now_cursor;
    logic [15:0] cur_thr [4];

    always #5 i_clk = ~i_clk;

    // Result side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (recv_hold_req != 0) begin
            hold_left     = recv_hold_req;
            recv_hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Observe every transaction on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                book.write_reg(cfg_ch.payload);
            if (in_ch.valid && in_ch.ready)
                book.take_sample(in_ch.payload);
            if (out_ch.valid && out_ch.ready)
                book.match_event(out_ch.payload);
        end
    end

    // Offer one sample, with a random gap first, and hold until it is taken
    task automatic send_sample(input logic pressed, input logic [31:0] now);
        t_in_item s;
        s.pressed = pressed;
        s.now_ms  = now;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic tap(input logic pressed, input logic [31:0] delta);
        now_cursor += delta;
        send_sample(pressed, now_cursor);
    endtask

    // Time step biased toward the current thresholds and their boundaries
    function automatic logic [31:0] pick_step();
        logic [31:0] t;
        int unsigned r;
        t = {16'd0, cur_thr[2'($urandom_range(3))]};
        r = $urandom_range(99);
        if (r < 10)      return 32'd0;
        else if (r < 25) return $urandom_range(1, 3);
        else if (r < 45) return t;
        else if (r < 60) return t + 32'd1;
        else if (r < 85) return $urandom_range(0, t * 2 + 2);
        else if (r < 97) return $urandom_range(0, 70000);
        else             return $urandom;
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        t_cfg_item w;
        w.index = idx;
        w.data  = val;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Pause the sender until every due event has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (book.due_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One gesture: alternating contact runs with occasional bounces
    task automatic run_gesture(inout int count);
        int   kind;
        int   runs;
        int   len;
        logic lvl;
        kind = $urandom_range(3);
        case (kind)
            0, 2:    runs = 2;
            1:       runs = 4;
            default: runs = $urandom_range(1, 6);
        endcase
        lvl = (kind == 3) ? logic'($urandom_range(1)) : 1'b1;
        for (int k = 0; k < runs; k++) begin
            len = (kind == 2 && lvl) ? $urandom_range(6, 20) : $urandom_range(1, 6);
            repeat (len) begin
                now_cursor += pick_step();
                send_sample(lvl ^ ($urandom_range(9) == 0), now_cursor);
                count++;
            end
            lvl = ~lvl;
        end
    endtask

    // Drain, load a threshold set, then run random gestures under one idling mode
    task automatic run_phase(input logic [15:0] deb, input logic [15:0] lng,
                             input logic [15:0] rpt, input logic [15:0] win,
                             input int unsigned snd_pct, input int unsigned rcv_pct,
                             input int unsigned hold, input int items);
        int count;
        bit held;
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_REPEAT, rpt);
        write_reg(REG_DOUBLE_WINDOW, win);
        // stray index must leave every threshold alone
        write_reg(8'($urandom_range(REG_DOUBLE_WINDOW + 1, 255)), 16'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_thr[0]     = deb;
        cur_thr[1]     = lng;
        cur_thr[2]     = rpt;
        cur_thr[3]     = win;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        now_cursor     = $urandom;
        count          = 0;
        held           = 0;
        while (count < items) begin
            run_gesture(count);
            if (hold != 0 && !held && count >= items / 2) begin
                recv_hold_req = hold;
                held          = 1;
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_req  = 0;
        hold_left      = 0;
        cur_thr[0]     = RST_DEBOUNCE;
        cur_thr[1]     = RST_LONG_PRESS;
        cur_thr[2]     = RST_REPEAT;
        cur_thr[3]     = RST_DOUBLE_WINDOW;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Time extremes, then a press crossing the wrap at reset thresholds
        now_cursor = 32'hFFFF_FFFF;
        tap(1'b0, 0);
        tap(1'b0, 1);
        now_cursor = 32'hFFFF_FFF0;
        tap(1'b1, 0);
        tap(1'b1, 20);
        tap(1'b1, 1);
        tap(1'b1, 500);
        // bounce while releasing, then long press with repeat
        tap(1'b0, 3);
        tap(1'b1, 5);
        tap(1'b1, 495);
        tap(1'b1, 501);
        tap(1'b1, 200);
        tap(1'b1, 1);
        // release from long hold goes straight to idle
        tap(1'b0, 7);
        // click, then a double click with a bounce on the second release
        tap(1'b1, 50);
        tap(1'b1, 21);
        tap(1'b0, 30);
        tap(1'b0, 21);
        tap(1'b1, 100);
        tap(1'b1, 21);
        tap(1'b0, 2);
        tap(1'b1, 1);
        tap(1'b0, 1);
        tap(1'b0, 21);

        run_phase(RST_DEBOUNCE, RST_LONG_PRESS, RST_REPEAT, RST_DOUBLE_WINDOW,
                  0, 0, 300, 190);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 59, 0, 0, 190);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 59, 0, 190);
        run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 600)), 16'($urandom_range(0, 900)),
                  7, 7, 0, 190);
        run_phase(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 0, 0, 0, 190);
        run_phase(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 59, 0, 0, 190);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  0, 59, 400, 190);
        run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 1500)),
                  16'($urandom_range(0, 300)), 16'($urandom_range(0, 400)),
                  7, 7, 0, 190);

        // Let the last events arrive, then a short tail
        in_ch.valid <= 1'b0;
        while (book.due_events.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (book.failures == 0 && book.due_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop far past the slowest correct run
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
